// File: rtl/rc_ppm_frame_generator_core_macros.svh
// assertion helpers used by the rtl core
`ifndef RC_PPM_FRAME_GENERATOR_CORE_MACROS_SVH
`define RC_PPM_FRAME_GENERATOR_CORE_MACROS_SVH

// same-cycle check, sampled on clk, off while arst_n is low
`define RCPPM_ASSERT_NOW(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle check, sampled on clk, off while arst_n is low
`define RCPPM_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: rtl/rcppm_pkg.sv
package rcppm_pkg;

	// item opcodes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SET  = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_SYNC_TICKS   = 2'd0;
	localparam logic [1:0] CFG_FRAME_TICKS  = 2'd1;
	localparam logic [1:0] CFG_INVERT       = 2'd2;
	localparam logic [1:0] CFG_FIRST_SLOT   = 2'd3;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	// register reset values
	localparam logic [9:0]  RESET_SYNC_TICKS  = 10'd75;
	localparam logic [15:0] RESET_FRAME_TICKS = 16'd5000;
	localparam logic        RESET_INVERT      = 1'b1;
	localparam logic [15:0] RESET_FIRST_SLOT  = 16'd250;

	// pulse timing in microseconds
	localparam int unsigned SYNC_US   = 300;
	localparam int unsigned BASE_US   = 1000;
	localparam int unsigned STICK_MAX = 1000;

	// stick channels fed by a set item
	localparam int STICKS = 4;

	// x*255/65 == 3x + (12x)/13, the last via reciprocal 2^16/13 rounded up
	localparam logic [12:0] RECIP_13  = 13'd5042;
	localparam int          RECIP_SHR = 16;

	typedef struct packed {
		logic       op;
		logic [7:0] throttle_in;
		logic [7:0] roll_in;
		logic [7:0] aileron_in;
		logic [7:0] elevator_in;
	} cmd_t;

	typedef struct packed {
		logic       ppm_level;
		logic [2:0] slot_number;
		logic       slot_start;
	} res_t;

	function automatic logic [9:0] scale_stick(input logic [7:0] x);
		logic [11:0] twelve_x;
		logic [24:0] prod;
		logic [10:0] val;
		twelve_x = {1'b0, x, 3'b000} + {2'b00, x, 2'b00};
		prod     = 25'(twelve_x) * 25'(RECIP_13);
		val      = 11'(x) + {2'b00, x, 1'b0} + 11'(prod[24:RECIP_SHR]);
		if (val > 11'(STICK_MAX)) begin
			val = 11'(STICK_MAX);
		end
		return val[9:0];
	endfunction

endpackage

// File: rtl/rc_ppm_frame_generator_core.sv
// RC PPM pulse train generator. Each item is either one timer tick (op 0) or a load of four
// stick positions (op 1). Every accepted item yields exactly one result in the result register,
// giving the pin level, the current slot number (CHANNELS = idle slot) and a flag for the
// tick on which the period counter wrapped. One item is accepted per clock cycle while no
// result waits untaken; a new item is taken in the same cycle a waiting result is taken,
// since the only storage between the two sides is the single result register. All per-tick
// work (counter compare and wrap, sync match, next slot length pick, idle remainder
// subtraction) is one pass of logic from the state registers to the result register. Slot
// lengths are (1300 + value) >> TICK_SHIFT ticks, refreshed from the latched sticks when the
// idle slot is chosen. Configuration writes take effect on the next item; the first slot
// length and initial idle remainder are fixed at reset.
`include "rc_ppm_frame_generator_core_macros.svh"

module rc_ppm_frame_generator_core #(
	parameter int CHANNELS   = 6,
	parameter int TICK_SHIFT = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [rcppm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [rcppm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                cmd_valid,
	output logic                                cmd_ready,
	input  rcppm_pkg::cmd_t                     cmd,
	output logic                                res_valid,
	input  logic                                res_ready,
	output rcppm_pkg::res_t                     res
);
	import rcppm_pkg::*;

	localparam int SLOT_W = $clog2(CHANNELS + 1);
	localparam int LEN_W  = 12;
	localparam logic [LEN_W-1:0] RESET_LEN = LEN_W'((BASE_US + SYNC_US) >> TICK_SHIFT);
	localparam logic [15:0] RESET_IDLE = RESET_FRAME_TICKS - RESET_FIRST_SLOT;

	function automatic logic [LEN_W-1:0] slot_len(input logic [9:0] v);
		logic [LEN_W-1:0] us;
		us = LEN_W'(BASE_US + SYNC_US) + LEN_W'(v);
		return us >> TICK_SHIFT;
	endfunction

	logic [9:0]       sync_ticks_q;
	logic [15:0]      frame_ticks_q;
	logic             invert_q;

	logic [15:0]      period_cnt_q;
	logic [15:0]      period_top_q;
	logic [15:0]      pending_top_q;
	logic [SLOT_W-1:0] slot_idx_q;
	logic [15:0]      idle_rem_q;
	logic [9:0]       stick_q [STICKS];
	logic [LEN_W-1:0] slot_len_q [STICKS];

	logic             res_valid_q;
	res_t             res_q;

	logic             accept;
	logic             is_tick;
	logic             tick_wrap;
	logic [15:0]      cnt_tick;
	logic             sync_hit;
	logic             frame_wrap;
	logic [SLOT_W-1:0] slot_nxt;
	logic             nxt_idle;
	logic [15:0]      idle_base;
	logic [15:0]      len_sel;
	logic [15:0]      idle_sub;
	logic [15:0]      cnt_new;
	logic [SLOT_W-1:0] slot_new;

	assign cmd_ready = !res_valid_q || res_ready;
	assign accept    = cmd_valid && cmd_ready;
	assign is_tick   = cmd.op == OP_TICK;

	assign tick_wrap  = period_cnt_q == period_top_q;
	assign cnt_tick   = tick_wrap ? 16'd0 : period_cnt_q + 16'd1;
	assign sync_hit   = cnt_tick == {6'd0, sync_ticks_q};
	assign frame_wrap = slot_idx_q == SLOT_W'(CHANNELS);
	assign slot_nxt   = frame_wrap ? '0 : slot_idx_q + SLOT_W'(1);
	assign nxt_idle   = slot_nxt == SLOT_W'(CHANNELS);
	assign idle_base  = frame_wrap ? frame_ticks_q : idle_rem_q;

	always_comb begin
		if (slot_nxt < SLOT_W'(STICKS)) begin
			len_sel = 16'(slot_len_q[slot_nxt[1:0]]);
		end else begin
			len_sel = 16'(RESET_LEN);
		end
		idle_sub = (idle_base > len_sel) ? idle_base - len_sel : 16'd0;
		cnt_new  = is_tick ? cnt_tick : period_cnt_q;
		slot_new = (is_tick && sync_hit) ? slot_nxt : slot_idx_q;
	end

	// configuration; first slot length only matters at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_ticks_q  <= RESET_SYNC_TICKS;
			frame_ticks_q <= RESET_FRAME_TICKS;
			invert_q      <= RESET_INVERT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SYNC_TICKS:  sync_ticks_q  <= cfg_data[9:0];
				CFG_FRAME_TICKS: frame_ticks_q <= cfg_data;
				CFG_INVERT:      invert_q      <= cfg_data[0];
				CFG_FIRST_SLOT: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_cnt_q  <= '0;
			period_top_q  <= RESET_FIRST_SLOT;
			pending_top_q <= RESET_FIRST_SLOT;
			slot_idx_q    <= '0;
			idle_rem_q    <= RESET_IDLE;
			for (int i = 0; i < STICKS; i++) begin
				stick_q[i]    <= '0;
				slot_len_q[i] <= RESET_LEN;
			end
		end else if (accept) begin
			if (!is_tick) begin
				stick_q[0] <= scale_stick(cmd.throttle_in);
				stick_q[1] <= scale_stick(cmd.roll_in);
				stick_q[2] <= scale_stick(cmd.aileron_in);
				stick_q[3] <= scale_stick(cmd.elevator_in);
			end else begin
				period_cnt_q <= cnt_tick;
				if (tick_wrap) begin
					period_top_q <= pending_top_q;
				end
				if (sync_hit) begin
					slot_idx_q <= slot_nxt;
					if (nxt_idle) begin
						pending_top_q <= idle_base;
						idle_rem_q    <= idle_base;
						for (int i = 0; i < STICKS; i++) begin
							slot_len_q[i] <= slot_len(stick_q[i]);
						end
					end else begin
						pending_top_q <= len_sel;
						idle_rem_q    <= idle_sub;
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.ppm_level   <= (cnt_new >= {6'd0, sync_ticks_q}) ^ !invert_q;
			res_q.slot_number <= slot_new[2:0];
			res_q.slot_start  <= is_tick && tick_wrap;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`RCPPM_ASSERT_NOW(a_slot_range, 1'b1, slot_idx_q <= SLOT_W'(CHANNELS),
		"slot index past idle slot")
	`RCPPM_ASSERT_NEXT(a_wrap_clears, accept && is_tick && tick_wrap,
		period_cnt_q == 16'd0 && res_q.slot_start, "wrap did not clear counter")
	`RCPPM_ASSERT_NEXT(a_tick_counts, accept && is_tick && !tick_wrap,
		period_cnt_q == 16'($past(period_cnt_q) + 16'd1), "counter did not advance")
	`RCPPM_ASSERT_NEXT(a_set_holds, accept && !is_tick,
		$stable(period_cnt_q) && $stable(slot_idx_q) && !res_q.slot_start,
		"set item moved the timer")

endmodule
